@@ hdl/miller_rabin_base_test_unit_defines.svh @@
// ----------------------------------------------------------------------------
// miller_rabin_base_test_unit_defines.svh
// Assertion macros shared by the Miller-Rabin base test unit.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_BASE_TEST_UNIT_DEFINES_SVH
`define MILLER_RABIN_BASE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRBT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mrbt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrbt_pkg
// Types and constants for the Miller-Rabin base test unit.
// ----------------------------------------------------------------------------
package mrbt_pkg;

    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        VERDICT_PROBABLE  = 2'd0,
        VERDICT_COMPOSITE = 2'd1,
        VERDICT_PRIME     = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_SQ,
        S_DONE
    } state_t;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

@@ hdl/miller_rabin_base_test_unit.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_base_test_unit
// Single-base Miller-Rabin witness test on a WIDTH-bit candidate.
// ----------------------------------------------------------------------------
// Each input word carries a candidate n and one trial base; each produces
// exactly one output word with a verdict (0 probable prime for this base,
// 1 composite, 2 certainly prime when n is two) and base_error, set when n
// is odd and at least three but the base lies outside 2..n-1 (verdict is
// then 0 and no test is run). Even n other than two, zero and one answer
// composite at once. A full test first splits n-1 into u*2^t, then for
// every bit of u runs one check step, one squaring and, where the bit is
// set, one multiply, then up to t more squarings; each multiply runs
// through the single shared shift-add unit at one bit per cycle. The block
// takes one word at a time:
// in_ready is high only when the sequencer is idle, while a finished result
// may still sit in the output register waiting for out_ready.
// ----------------------------------------------------------------------------
`include "miller_rabin_base_test_unit_defines.svh"

module miller_rabin_base_test_unit #(
    parameter int WIDTH = mrbt_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] n,
    input  logic [WIDTH-1:0] base,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       verdict,
    output logic             base_error
);
    import mrbt_pkg::*;

    localparam int TW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
    localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

    state_t state_reg, state_next;

    // working registers
    logic [WIDTH-1:0] n_reg,   n_next;
    logic [WIDTH-1:0] b_reg,   b_next;     // running power base
    logic [WIDTH-1:0] e_reg,   e_next;     // remaining exponent / n-1 split
    logic [WIDTH-1:0] acc_reg, acc_next;   // power accumulator, later prev
    logic [TW-1:0]    t_reg,   t_next;
    logic             issued_reg, issued_next;
    verdict_t         vd_reg,  vd_next;
    logic             err_reg, err_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    verdict_t         verdict_reg;
    logic             base_error_reg;
    logic             out_load;

    // multiplier hookup
    logic             mul_start;
    logic [WIDTH-1:0] mul_x;
    logic [WIDTH-1:0] mul_y;
    mul_stat_t        mul_stat;
    logic [WIDTH-1:0] mul_res;

    logic             accept;
    logic [WIDTH-1:0] n_minus_one;

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign n_minus_one = n_reg - ONE;

    mrbt_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (n_reg),
        .stat   (mul_stat),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        b_reg   <= b_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
        vd_reg  <= vd_next;
        err_reg <= err_next;
        if (out_load)
        begin
            verdict_reg    <= vd_reg;
            base_error_reg <= err_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        issued_next = issued_reg;
        vd_next     = vd_reg;
        err_next    = err_reg;
        mul_start   = 1'b0;
        mul_x       = acc_reg;
        mul_y       = b_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next   = n;
                    b_next   = base;
                    e_next   = n - ONE;
                    acc_next = ONE;
                    t_next   = '0;
                    err_next = 1'b0;
                    vd_next  = VERDICT_PROBABLE;
                    priority if (n == TWO)
                    begin
                        vd_next    = VERDICT_PRIME;
                        state_next = S_DONE;
                    end
                    else if (!n[0] || n == ONE)
                    begin
                        vd_next    = VERDICT_COMPOSITE;
                        state_next = S_DONE;
                    end
                    else if (base < TWO || base >= n)
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end

            S_SPLIT:
            begin
                // strip trailing zeros of n-1
                if (!e_reg[0])
                begin
                    e_next = {1'b0, e_reg[WIDTH-1:1]};
                    t_next = t_reg + 1'b1;
                end
                else
                begin
                    state_next = S_POW_CHK;
                end
            end

            S_POW_CHK:
            begin
                priority if (e_reg == '0)
                begin
                    state_next = S_SQ;
                end
                else if (e_reg[0])
                begin
                    state_next = S_POW_MUL;
                end
                else
                begin
                    state_next = S_POW_SQR;
                end
            end

            S_POW_MUL:
            begin
                mul_x = acc_reg;
                mul_y = b_reg;
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_stat.done)
                begin
                    acc_next    = mul_res;
                    issued_next = 1'b0;
                    state_next  = S_POW_SQR;
                end
            end

            S_POW_SQR:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_stat.done)
                begin
                    b_next      = mul_res;
                    e_next      = {1'b0, e_reg[WIDTH-1:1]};
                    issued_next = 1'b0;
                    state_next  = S_POW_CHK;
                end
            end

            S_SQ:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
                if (!issued_reg)
                begin
                    if (t_reg == '0)
                    begin
                        // Fermat check on the final value
                        vd_next    = (acc_reg != ONE) ? VERDICT_COMPOSITE
                                                      : VERDICT_PROBABLE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mul_start   = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (mul_stat.done)
                begin
                    issued_next = 1'b0;
                    // nontrivial square root of one
                    if (mul_res == ONE && acc_reg != ONE && acc_reg != n_minus_one)
                    begin
                        vd_next    = VERDICT_COMPOSITE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next = mul_res;
                        t_next   = t_reg - 1'b1;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign base_error = base_error_reg;

    // ---- assertions ----
    `MRBT_ASSERT_IMPL(a_start_idle_mul, mul_start, !mul_stat.busy && !mul_stat.done, "multiplier restarted while in flight")
    `MRBT_ASSERT_IMPL(a_done_issued, mul_stat.done, issued_reg, "multiplier result with no request outstanding")
    `MRBT_ASSERT_IMPL(a_acc_reduced, state_reg == S_SQ || state_reg == S_POW_MUL || state_reg == S_POW_SQR, acc_reg < n_reg && b_reg < n_reg, "working value not reduced modulo n")
    `MRBT_ASSERT_IMPL(a_err_verdict, out_valid && base_error, verdict == VERDICT_PROBABLE, "base error with a nonzero verdict")
    `MRBT_ASSERT_NEXT(a_load_valid, out_load, out_valid, "loaded result not presented")

endmodule

@@ hdl/mrbt_modmul.sv @@
// ----------------------------------------------------------------------------
// mrbt_modmul
// Shift-add modular multiplier: x * y mod m, one bit of y per cycle, x < m.
// ----------------------------------------------------------------------------
module mrbt_modmul #(
    parameter int WIDTH = mrbt_pkg::WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   x,
    input  logic [WIDTH-1:0]   y,
    input  logic [WIDTH-1:0]   m,
    output mrbt_pkg::mul_stat_t stat,
    output logic [WIDTH-1:0]   result
);
    import mrbt_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;

    // 2*acc + bit*x < 3m, so at most two subtractions of m
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (y_reg[WIDTH-1] ? {2'b00, x_reg} : '0);
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        priority if (sum >= m2)
        begin
            acc_next = WIDTH'(sum - m2);
        end
        else if (sum >= m1)
        begin
            acc_next = WIDTH'(sum - m1);
        end
        else
        begin
            acc_next = WIDTH'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule
